// ===== hw/rtl/irx_pkg.sv =====
// ----------------------------------------------------------------------------
// irx_pkg
// Shared types and constants of the register ALU executor.
// ----------------------------------------------------------------------------
`default_nettype none

package irx_pkg;

    localparam int NUM_REGS_DEFAULT = 32;
    localparam int IDX_W            = 5;
    localparam int DATA_W           = 64;
    localparam int SHAMT_W          = 6;
    localparam int S_TDATA_W        = 160;
    localparam int M_TDATA_W        = 136;

    typedef enum logic [3:0] {
        FN_NOP     = 4'd0,
        FN_MOVE    = 4'd1,
        FN_BR      = 4'd2,
        FN_BRNZ    = 4'd3,
        FN_LDI     = 4'd4,
        FN_ADD     = 4'd5,
        FN_ADDI    = 4'd6,
        FN_SUB     = 4'd7,
        FN_SUBI    = 4'd8,
        FN_ANDI    = 4'd9,
        FN_ANDC    = 4'd10,
        FN_OR      = 4'd11,
        FN_ORI     = 4'd12,
        FN_SLL32   = 4'd13,
        FN_SLL64   = 4'd14,
        FN_INVALID = 4'd15
    } func_t;

    // request as packed on s_tdata, last field (func) in the low bits
    typedef struct packed {
        logic [DATA_W-1:0]  branch_target;
        logic [SHAMT_W-1:0] shift_amount;
        logic [DATA_W-1:0]  imm;
        logic [IDX_W-1:0]   dest;
        logic [IDX_W-1:0]   src_b;
        logic [IDX_W-1:0]   src_a;
        func_t              func;
    } req_t;

    localparam int REQ_W = $bits(req_t);

    // result as packed on m_tdata, last field (ok) in the low bits
    typedef struct packed {
        logic [DATA_W-1:0] written_value;
        logic              reg_written;
        logic [DATA_W-1:0] pc_out;
        logic              branch_taken;
        logic              ok;
    } res_t;

    localparam int RES_W = $bits(res_t);

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx_a;
        logic [IDX_W-1:0] idx_b;
    } rf_rd_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
    } rf_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/irx_ram.sv =====
// ----------------------------------------------------------------------------
// irx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module irx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/irx_regfile.sv =====
// ----------------------------------------------------------------------------
// irx_regfile
// Two-read, one-write register file on two mirrored RAMs, with per-entry
// valid bits for reset and bypass of a write landing on the read edge.
// ----------------------------------------------------------------------------
`default_nettype none

module irx_regfile
    import irx_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rf_rd_t            rd,
    input  wire rf_wr_t            wr,
    output logic      [DATA_W-1:0] opnd_a,
    output logic      [DATA_W-1:0] opnd_b
);

    localparam int ADDR_W = $clog2(NUM_REGS);

    logic [ADDR_W-1:0]   addr_a;
    logic [ADDR_W-1:0]   addr_b;
    logic [ADDR_W-1:0]   addr_w;
    logic                inr_a;
    logic                inr_b;
    logic [DATA_W-1:0]   ram_a;
    logic [DATA_W-1:0]   ram_b;
    logic [NUM_REGS-1:0] valid_reg;
    logic                va_reg;
    logic                vb_reg;
    logic                hit_a_reg;
    logic                hit_b_reg;
    logic [DATA_W-1:0]   fwd_data_reg;

    assign addr_a = ADDR_W'(rd.idx_a);
    assign addr_b = ADDR_W'(rd.idx_b);
    assign addr_w = ADDR_W'(wr.idx);
    assign inr_a  = (32'(rd.idx_a) < NUM_REGS);
    assign inr_b  = (32'(rd.idx_b) < NUM_REGS);

    irx_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_a (
        .aclk    (aclk),
        .wr_en   (wr.en),
        .wr_addr (addr_w),
        .wr_data (wr.data),
        .rd_en   (rd.en),
        .rd_addr (addr_a),
        .rd_data (ram_a)
    );

    irx_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_b (
        .aclk    (aclk),
        .wr_en   (wr.en),
        .wr_addr (addr_w),
        .wr_data (wr.data),
        .rd_en   (rd.en),
        .rd_addr (addr_b),
        .rd_data (ram_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[addr_w] <= 1'b1;
            end
            if (rd.en) begin
                va_reg    <= inr_a && valid_reg[addr_a];
                vb_reg    <= inr_b && valid_reg[addr_b];
                // write on the same edge is not yet visible in the RAM
                hit_a_reg <= wr.en && (wr.idx == rd.idx_a);
                hit_b_reg <= wr.en && (wr.idx == rd.idx_b);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            fwd_data_reg <= wr.data;
        end
    end

    assign opnd_a = hit_a_reg ? fwd_data_reg : (va_reg ? ram_a : '0);
    assign opnd_b = hit_b_reg ? fwd_data_reg : (vb_reg ? ram_b : '0);

endmodule

`default_nettype wire

// ===== hw/rtl/irx_alu.sv =====
// ----------------------------------------------------------------------------
// irx_alu
// Decode and execute of one request: result value, write-back and branch.
// ----------------------------------------------------------------------------
`default_nettype none

module irx_alu
    import irx_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEFAULT
) (
    input  wire req_t              req,
    input  wire logic [DATA_W-1:0] opnd_a,
    input  wire logic [DATA_W-1:0] opnd_b,
    input  wire logic [DATA_W-1:0] pc,
    output res_t                   res,
    output rf_wr_t                 wr
);

    logic [DATA_W-1:0] val;
    logic [31:0]       sll32_lo;
    logic              ok;
    logic              writes;
    logic              taken;
    logic              do_write;

    assign sll32_lo = opnd_a[31:0] << req.shift_amount[4:0];

    always_comb begin
        val    = '0;
        ok     = 1'b1;
        writes = 1'b1;
        taken  = 1'b0;
        unique case (req.func)
            FN_NOP:   writes = 1'b0;
            FN_MOVE:  val = opnd_a;
            FN_BR: begin
                writes = 1'b0;
                taken  = 1'b1;
            end
            FN_BRNZ: begin
                writes = 1'b0;
                taken  = (opnd_a != '0);
            end
            FN_LDI:   val = req.imm;
            FN_ADD:   val = opnd_a + opnd_b;
            FN_ADDI:  val = opnd_a + req.imm;
            FN_SUB:   val = opnd_b - opnd_a;
            FN_SUBI:  val = opnd_a - req.imm;
            FN_ANDI:  val = opnd_a & req.imm;
            FN_ANDC:  val = opnd_a & ~opnd_b;
            FN_OR:    val = opnd_a | opnd_b;
            FN_ORI:   val = opnd_a | req.imm;
            FN_SLL32: val = req.shift_amount[5] ? '0 : {32'd0, sll32_lo};
            FN_SLL64: val = opnd_a << req.shift_amount;
            default: begin
                ok     = 1'b0;
                writes = 1'b0;
            end
        endcase
    end

    // destination beyond the file drops the write
    assign do_write = writes && (32'(req.dest) < NUM_REGS);

    assign wr.en   = do_write;
    assign wr.idx  = req.dest;
    assign wr.data = val;

    assign res.ok            = ok;
    assign res.branch_taken  = taken;
    assign res.pc_out        = taken ? req.branch_target : pc;
    assign res.reg_written   = do_write;
    assign res.written_value = do_write ? val : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/ir_register_alu_executor_unit.sv =====
// ----------------------------------------------------------------------------
// ir_register_alu_executor_unit
// Executes one instruction per request against a 64-bit register file and
// a program counter, returning one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries instructions, m_ channel returns one result each.
//   Stage 0 issues the register reads into the RAMs on the accept edge;
//   stage 1 executes, writes back and loads the output register.
//   Output: m_tvalid rises when stage 1 moves its result into the output
//   register, which waits while that register is full and m_tready is low.
//   Throughput: one request per cycle while m_tready is high. A request that reads the register
//   written by the one just ahead of it is bypassed, so there are no
//   bubbles.
//   Reset: the program counter and all registers read as zero; the
//   register RAMs are not swept, per-entry valid bits mask stale data.
//   Stall: while m_tready is low and the output register is full, it and
//   stage 1 hold; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_register_alu_executor_unit
    import irx_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // func, src_a, src_b, dest, imm, shift_amount, branch_target
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // ok, branch_taken, pc_out, reg_written, written_value
    output logic      [M_TDATA_W-1:0] m_tdata
);

    req_t              in_req;
    req_t              s1_req_reg;
    logic              s1_valid_reg;
    logic              m_valid_reg;
    res_t              m_res_reg;
    logic [DATA_W-1:0] pc_reg;
    logic              s_accept;
    logic              advance;
    logic [DATA_W-1:0] opnd_a;
    logic [DATA_W-1:0] opnd_b;
    res_t              alu_res;
    rf_wr_t            alu_wr;
    rf_wr_t            rf_wr;
    rf_rd_t            rf_rd;

    assign in_req   = req_t'(s_tdata[REQ_W-1:0]);
    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign rf_rd.en    = s_accept;
    assign rf_rd.idx_a = in_req.src_a;
    assign rf_rd.idx_b = in_req.src_b;

    assign rf_wr.en   = alu_wr.en && advance;
    assign rf_wr.idx  = alu_wr.idx;
    assign rf_wr.data = alu_wr.data;

    irx_regfile #(.NUM_REGS(NUM_REGS)) u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (rf_rd),
        .wr      (rf_wr),
        .opnd_a  (opnd_a),
        .opnd_b  (opnd_b)
    );

    irx_alu #(.NUM_REGS(NUM_REGS)) u_alu (
        .req    (s1_req_reg),
        .opnd_a (opnd_a),
        .opnd_b (opnd_b),
        .pc     (pc_reg),
        .res    (alu_res),
        .wr     (alu_wr)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            pc_reg       <= '0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (advance && alu_res.branch_taken) begin
                pc_reg <= alu_res.pc_out;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_req_reg <= in_req;
        end
        if (advance) begin
            m_res_reg <= alu_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RES_W){1'b0}}, m_res_reg};

    // a written register implies a valid opcode
    a_write_ok : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[66] |-> m_tdata[0])
        else $error("register write reported for an invalid opcode");

    // taken branches never write the file
    a_branch_nowrite : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> !m_tdata[66])
        else $error("branch result also reports a register write");

    // written value is zero unless a write happened
    a_value_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[66] |-> (m_tdata[130:67] == '0))
        else $error("nonzero written value without a register write");

    // input stalls only when both stage 1 and the output register are full
    a_stall_full : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
